// ===== hw/rtl/longest_prefix_route_lookup_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the route lookup block
// Concurrent checks that are compiled out when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef LONGEST_PREFIX_ROUTE_LOOKUP_DEFINES_SVH
`define LONGEST_PREFIX_ROUTE_LOOKUP_DEFINES_SVH

`ifndef SYNTHESIS

// condition must hold on every clock edge out of reset
`define LPR_ASSERT_HOLDS(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
		else $error("lpr: invariant violated");

// same-cycle implication
`define LPR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("lpr: implication violated");

// next-cycle implication
`define LPR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("lpr: next-cycle check violated");

`else

`define LPR_ASSERT_HOLDS(lbl, clk, rst_n, cond)
`define LPR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define LPR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== hw/rtl/lpr_pkg.sv =====
// ----------------------------------------------------------------------------
// lpr_pkg
// Shared constants, types and helpers of the route lookup cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

package lpr_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int ADDR_W      = 32;
	localparam int PORT_W      = 4;
	localparam int LEN_W       = 6;

	typedef enum logic {
		CMD_INSERT = 1'b0,
		CMD_LOOKUP = 1'b1
	} lpr_cmd_t;

	// One request as it travels down the chain. For an insert the route
	// fields carry the new entry and cnt is its slot; for a lookup they
	// carry the best match so far and cnt is the fill count at entry.
	typedef struct packed {
		lpr_cmd_t            cmd;
		logic                full;
		logic                hit;
		logic [ADDR_W-1:0]   addr;
		logic [ADDR_W-1:0]   dest;
		logic [ADDR_W-1:0]   gw;
		logic [ADDR_W-1:0]   mask;
		logic [PORT_W-1:0]   port;
		logic [LEN_W-1:0]    len;
		logic [CNT_W-1:0]    cnt;
	} lpr_item_t;

	// Ones count of a mask as a five level adder tree
	function automatic logic [LEN_W-1:0] popcount32(input logic [ADDR_W-1:0] v);
		logic [1:0] l1 [16];
		logic [2:0] l2 [8];
		logic [3:0] l3 [4];
		logic [4:0] l4 [2];
		for (int i = 0; i < 16; i++) begin
			l1[i] = {1'b0, v[2*i]} + {1'b0, v[2*i+1]};
		end
		for (int i = 0; i < 8; i++) begin
			l2[i] = {1'b0, l1[2*i]} + {1'b0, l1[2*i+1]};
		end
		for (int i = 0; i < 4; i++) begin
			l3[i] = {1'b0, l2[2*i]} + {1'b0, l2[2*i+1]};
		end
		for (int i = 0; i < 2; i++) begin
			l4[i] = {1'b0, l3[2*i]} + {1'b0, l3[2*i+1]};
		end
		return {1'b0, l4[0]} + {1'b0, l4[1]};
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/lpr_cell.sv =====
// ----------------------------------------------------------------------------
// lpr_cell
// One route slot of the chain: holds an entry, claims the insert aimed at
// its slot and improves the best match of each passing lookup.
// ----------------------------------------------------------------------------
`default_nettype none

module lpr_cell (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    adv,
	input  wire logic [lpr_pkg::IDX_W-1:0] slot,
	input  wire logic                    prev_valid,
	input  wire lpr_pkg::lpr_item_t      prev_item,
	output logic                         next_valid,
	output lpr_pkg::lpr_item_t           next_item
);
	import lpr_pkg::*;

	logic [ADDR_W-1:0] dest_q;
	logic [ADDR_W-1:0] gw_q;
	logic [ADDR_W-1:0] mask_q;
	logic [PORT_W-1:0] port_q;
	logic [LEN_W-1:0]  len_q;

	logic              valid_q;
	lpr_item_t         item_q;
	lpr_item_t         upd;
	logic [CNT_W-1:0]  slot_ext;
	logic              claim;
	logic              better;

	assign slot_ext = CNT_W'(slot);

	// insert aimed at this slot
	assign claim = prev_valid && (prev_item.cmd == CMD_INSERT) && (prev_item.cnt == slot_ext);

	// lookup: slot filled, masked compare, strictly longer prefix wins
	assign better = (prev_item.cmd == CMD_LOOKUP) && (slot_ext < prev_item.cnt)
		&& (((prev_item.addr ^ dest_q) & mask_q) == '0)
		&& (!prev_item.hit || (len_q > prev_item.len));

	always_comb begin
		upd = prev_item;
		if (better) begin
			upd.hit  = 1'b1;
			upd.dest = dest_q;
			upd.gw   = gw_q;
			upd.mask = mask_q;
			upd.port = port_q;
			upd.len  = len_q;
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (adv && claim) begin
			dest_q <= prev_item.dest;
			gw_q   <= prev_item.gw;
			mask_q <= prev_item.mask;
			port_q <= prev_item.port;
			len_q  <= prev_item.len;
		end
	end

	// hand-off to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= prev_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_q <= upd;
		end
	end

	assign next_valid = valid_q;
	assign next_item  = item_q;

endmodule

`default_nettype wire

// ===== hw/rtl/longest_prefix_route_lookup.sv =====
// ----------------------------------------------------------------------------
// longest_prefix_route_lookup
// IPv4 route table with longest prefix match, built as a chain of slot cells.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid / req_stall): command 0 appends a route at the
//   next free slot, command 1 looks up lookup_address. A request is taken on
//   an edge with req_valid high and req_stall low.
//   Response channel (rsp_valid / rsp_stall): exactly one response per
//   request, in request order. Lookups return the matching route with the
//   most mask ones (earliest insert on ties); inserts return table_full.
//   Pipeline: a request walks one cell per cycle through the 64 slot cells
//   while the chain is not stalled, and rsp_valid rises when the last cell
//   registers it; the response is taken on an edge with rsp_stall low.
//   Throughput: one request per cycle; the chain moves every cycle that the
//   response is taken or the last cell is empty, so inserts and lookups may
//   be freely interleaved back to back.
//   Stall: while rsp_valid is high and rsp_stall is high the whole chain
//   freezes and req_stall is raised; the response stays unchanged.
//   Reset: arst_n clears the fill count and all cell valid bits; the table
//   is empty afterwards and ready at once.
// ----------------------------------------------------------------------------
`default_nettype none

module longest_prefix_route_lookup (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        req_valid,
	output logic             req_stall,
	input  wire logic        command,
	input  wire logic [31:0] lookup_address,
	input  wire logic [31:0] entry_destination,
	input  wire logic [31:0] entry_gateway,
	input  wire logic [31:0] entry_netmask,
	input  wire logic [3:0]  entry_port,
	output logic             rsp_valid,
	input  wire logic        rsp_stall,
	output logic             found,
	output logic [31:0]      match_destination,
	output logic [31:0]      match_gateway,
	output logic [31:0]      match_netmask,
	output logic [3:0]       match_port,
	output logic [5:0]       prefix_length,
	output logic             table_full
);
	import lpr_pkg::*;

	logic              adv;
	logic              req_acc;
	logic              ins_acc;
	logic              is_full;
	logic [CNT_W-1:0]  fill_count_q;
	lpr_item_t         ing;
	lpr_item_t         tail;
	logic              link_valid [TABLE_DEPTH+1];
	lpr_item_t         link_item  [TABLE_DEPTH+1];

	// chain moves unless a held response is stalled
	assign adv       = !(rsp_valid && rsp_stall);
	assign req_stall = !adv;
	assign req_acc   = req_valid && adv;
	assign is_full   = (fill_count_q == CNT_W'(TABLE_DEPTH));
	assign ins_acc   = req_acc && (lpr_cmd_t'(command) == CMD_INSERT) && !is_full;

	// fill count: slot of the next insert
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_count_q <= '0;
		end else if (ins_acc) begin
			fill_count_q <= fill_count_q + CNT_W'(1);
		end
	end

	// build the request entering cell 0
	always_comb begin
		ing      = '0;
		ing.cmd  = lpr_cmd_t'(command);
		ing.addr = lookup_address;
		ing.cnt  = fill_count_q;
		if (lpr_cmd_t'(command) == CMD_INSERT) begin
			ing.full = is_full;
			ing.dest = entry_destination;
			ing.gw   = entry_gateway;
			ing.mask = entry_netmask;
			ing.port = entry_port;
			ing.len  = popcount32(entry_netmask);
		end
	end

	assign link_valid[0] = req_valid;
	assign link_item[0]  = ing;

	// slot cells, slot 0 first so that earlier inserts win ties
	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		lpr_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.adv        (adv),
			.slot       (IDX_W'(i)),
			.prev_valid (link_valid[i]),
			.prev_item  (link_item[i]),
			.next_valid (link_valid[i+1]),
			.next_item  (link_item[i+1])
		);
	end

	// response formatting from the last cell
	assign tail              = link_item[TABLE_DEPTH];
	assign rsp_valid         = link_valid[TABLE_DEPTH];
	assign found             = (tail.cmd == CMD_LOOKUP) && tail.hit;
	assign match_destination = found ? tail.dest : '0;
	assign match_gateway     = found ? tail.gw   : '0;
	assign match_netmask     = found ? tail.mask : '0;
	assign match_port        = found ? tail.port : '0;
	assign prefix_length     = found ? tail.len  : '0;
	assign table_full        = (tail.cmd == CMD_INSERT) && tail.full;

`include "longest_prefix_route_lookup_defines.svh"

	`LPR_ASSERT_HOLDS(a_fill_bound, clk, arst_n, fill_count_q <= CNT_W'(TABLE_DEPTH))
	`LPR_ASSERT_IMPL(a_stall_back, clk, arst_n, rsp_valid && rsp_stall, req_stall)
	`LPR_ASSERT_NEXT(a_fill_step, clk, arst_n, ins_acc, fill_count_q == $past(fill_count_q) + CNT_W'(1))
	`LPR_ASSERT_IMPL(a_found_excl, clk, arst_n, rsp_valid && found, !table_full)

endmodule

`default_nettype wire
